// ===== design/rip_relative_reference_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// rip-relative reference scanner assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RIP_RELATIVE_REFERENCE_SCANNER_MACROS_SVH
`define RIP_RELATIVE_REFERENCE_SCANNER_MACROS_SVH

// same-cycle implication
`define RRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/rrs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrs_pkg
// types and opcode constants of the rip-relative reference scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrs_pkg;

  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned WINDOW_DEPTH = 6;

  localparam logic [7:0] OPC_GROUP5     = 8'hFF;
  localparam logic [7:0] MODRM_CALL_RIP = 8'h15;
  localparam logic [7:0] MODRM_JMP_RIP  = 8'h25;
  localparam logic [7:0] PFX_REX_W      = 8'h48;
  localparam logic [7:0] OPC_MOV_LOAD   = 8'h8B;
  localparam logic [7:0] MODRM_RIP_MASK = 8'hC7;
  localparam logic [7:0] MODRM_RIP      = 8'h05;

  localparam logic KIND_BRANCH = 1'b0;
  localparam logic KIND_MOV    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTION_BASE = 2'd0,
    CFG_TARGET_BASE  = 2'd1,
    CFG_TARGET_SIZE  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] section_base;
    logic [63:0] target_base;
    logic [63:0] target_end;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] start;
    logic [63:0] rel;
  } cand_t;

endpackage

`default_nettype wire

// ===== design/rrs_if.sv =====
// ----------------------------------------------------------------------------
// rrs channel interfaces
// code byte request, site result and configuration write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rrs_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       section_end;
  modport source (output valid, code_byte, section_end, input ready);
  modport sink   (input valid, code_byte, section_end, output ready);
endinterface

interface rrs_site_if;
  logic        valid;
  logic        ready;
  logic [63:0] site_address;
  logic        site_kind;
  logic        run_last;
  modport source (output valid, site_address, site_kind, run_last, input ready);
  modport sink   (input valid, site_address, site_kind, run_last, output ready);
endinterface

interface rrs_cfg_if;
  import rrs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/rrs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// rrs_cfg_regs
// configuration registers with the target range end kept precomputed
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rrs_cfg_regs (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  rrs_cfg_if.sink       cfg_i,
  output rrs_pkg::cfg_t cfg_o
);
  import rrs_pkg::*;

  logic [63:0] section_base_q, section_base_d;
  logic [63:0] target_base_q, target_base_d;
  logic [63:0] target_size_q, target_size_d;
  logic [63:0] target_end_q, target_end_d;
  logic        wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;

  always_comb begin
    section_base_d = section_base_q;
    target_base_d  = target_base_q;
    target_size_d  = target_size_q;
    target_end_d   = target_end_q;
    if (wr) begin
      unique case (cfg_i.index)
        CFG_SECTION_BASE: section_base_d = cfg_i.data;
        CFG_TARGET_BASE: begin
          target_base_d = cfg_i.data;
          target_end_d  = cfg_i.data + target_size_q;
        end
        CFG_TARGET_SIZE: begin
          target_size_d = cfg_i.data;
          target_end_d  = target_base_q + cfg_i.data;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      section_base_q <= '0;
      target_base_q  <= '0;
      target_size_q  <= '0;
      target_end_q   <= '0;
    end else begin
      section_base_q <= section_base_d;
      target_base_q  <= target_base_d;
      target_size_q  <= target_size_d;
      target_end_q   <= target_end_d;
    end
  end

  assign cfg_o.section_base = section_base_q;
  assign cfg_o.target_base  = target_base_q;
  assign cfg_o.target_end   = target_end_q;

endmodule

`default_nettype wire

// ===== design/rrs_decode.sv =====
// ----------------------------------------------------------------------------
// rrs_decode
// byte window, section position and opcode match into the candidate register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rip_relative_reference_scanner_macros.svh"

module rrs_decode #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  rrs_code_if.sink       code_i,
  output rrs_pkg::cand_t cand_o,
  output logic           cand_valid_o,
  input  wire logic      cand_ready_i
);
  import rrs_pkg::*;

  logic [7:0]             win_q [WINDOW_DEPTH];
  logic [7:0]             win_d [WINDOW_DEPTH];
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic                   cand_v_q, cand_v_d;
  cand_t                  cand_q;

  logic                   load_en;
  logic                   accept;
  logic [31:0]            disp;
  logic                   mov_hit;
  logic                   ff_hit;
  logic [OFFSET_BITS-1:0] start;

  assign load_en      = !cand_v_q || cand_ready_i;
  assign code_i.ready = load_en;
  assign accept       = code_i.valid && load_en;

  assign disp = {code_i.code_byte, win_q[5], win_q[4], win_q[3]};

  assign mov_hit = (pos_q >= OFFSET_BITS'(6)) && (win_q[0] == PFX_REX_W) &&
                   (win_q[1] == OPC_MOV_LOAD) &&
                   ((win_q[2] & MODRM_RIP_MASK) == MODRM_RIP);
  assign ff_hit  = (pos_q >= OFFSET_BITS'(5)) && (win_q[1] == OPC_GROUP5) &&
                   ((win_q[2] == MODRM_CALL_RIP) || (win_q[2] == MODRM_JMP_RIP));
  assign start   = pos_q - (mov_hit ? OFFSET_BITS'(6) : OFFSET_BITS'(5));

  always_comb begin
    win_d    = win_q;
    pos_d    = pos_q;
    cand_v_d = cand_v_q;
    if (load_en) begin
      cand_v_d = accept && (mov_hit || ff_hit);
    end
    if (accept) begin
      if (code_i.section_end) begin
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          win_d[i] = '0;
        end
        pos_d = '0;
      end else begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          win_d[i] = win_q[i+1];
        end
        win_d[WINDOW_DEPTH-1] = code_i.code_byte;
        if (pos_q != '1) begin
          pos_d = pos_q + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        win_q[i] <= '0;
      end
      pos_q    <= '0;
      cand_v_q <= 1'b0;
    end else begin
      win_q    <= win_d;
      pos_q    <= pos_d;
      cand_v_q <= cand_v_d;
    end
  end

  // start plus length is position plus one for both kinds
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q.kind  <= mov_hit ? KIND_MOV : KIND_BRANCH;
      cand_q.start <= 64'(start);
      cand_q.rel   <= 64'(pos_q) + 64'd1 + {{32{disp[31]}}, disp};
    end
  end

  assign cand_o       = cand_q;
  assign cand_valid_o = cand_v_q;

  `RRS_ASSERT_NEXT(a_end_clears_pos, accept && code_i.section_end, pos_q == '0)
  `RRS_ASSERT_NEXT(a_cand_holds, cand_v_q && !cand_ready_i, cand_v_q && $stable(cand_q))
  `RRS_ASSERT_NOW(a_kinds_exclusive, 1'b1, !(mov_hit && ff_hit))

endmodule

`default_nettype wire

// ===== design/rrs_resolve.sv =====
// ----------------------------------------------------------------------------
// rrs_resolve
// target address sum, range check and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rip_relative_reference_scanner_macros.svh"

module rrs_resolve (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  rrs_pkg::cfg_t  cfg_i,
  input  rrs_pkg::cand_t cand_i,
  input  wire logic      cand_valid_i,
  output logic           cand_ready_o,
  rrs_site_if.source     site_o
);
  import rrs_pkg::*;

  logic        sum_v_q;
  logic        sum_kind_q;
  logic [63:0] sum_target_q;
  logic [63:0] sum_addr_q;
  logic        out_v_q, out_v_d;
  logic        out_kind_q;
  logic [63:0] out_addr_q;
  logic        out_free;
  logic        sum_en;
  logic        in_range;

  assign out_free     = !out_v_q || site_o.ready;
  assign sum_en       = !sum_v_q || out_free;
  assign cand_ready_o = sum_en;

  assign in_range = (sum_target_q >= cfg_i.target_base) &&
                    (sum_target_q < cfg_i.target_end);

  always_comb begin
    out_v_d = out_v_q;
    if (out_free) begin
      out_v_d = sum_v_q && in_range;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (sum_en) begin
        sum_v_q <= cand_valid_i;
      end
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en && cand_valid_i) begin
      sum_kind_q   <= cand_i.kind;
      sum_target_q <= cfg_i.section_base + cand_i.rel;
      sum_addr_q   <= cfg_i.section_base + cand_i.start;
    end
    if (out_free && sum_v_q) begin
      out_kind_q <= sum_kind_q;
      out_addr_q <= sum_addr_q;
    end
  end

  assign site_o.valid        = out_v_q;
  assign site_o.site_address = out_addr_q;
  assign site_o.site_kind    = out_kind_q;
  assign site_o.run_last     = 1'b1;

  `RRS_ASSERT_NEXT(a_cand_taken, cand_valid_i && sum_en, sum_v_q)
  `RRS_ASSERT_NOW(a_out_from_sum, $rose(out_v_q), $past(sum_v_q))

endmodule

`default_nettype wire

// ===== design/rip_relative_reference_scanner.sv =====
// ----------------------------------------------------------------------------
// rip_relative_reference_scanner
// finds rip-relative call/jmp and mov loads whose target lies in a range
// ----------------------------------------------------------------------------
// code_i takes one code byte per request, section_end on the final byte of a
// section; site_o returns the start address of each matching instruction,
// at most one per byte, so run_last is always set. the user must write
// section_base, target_base and target_size over cfg_i only while no byte is
// in flight; the block does not enforce it. an instruction is detected on
// the request that carries its last byte. site_o.valid rises after the byte
// passes the candidate, address sum and result registers. throughput: one
// byte per cycle while site_o does not stall, set by the three-register
// pipeline with a single 64-bit add or compare pair per stage.
// reset clears the byte window, the position, the configuration registers and
// all valid flags. when site_o stalls, the result register holds and the two
// stages behind it keep filling; code_i.ready drops only when every stage is
// full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rip_relative_reference_scanner #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rrs_code_if.sink   code_i,
  rrs_cfg_if.sink    cfg_i,
  rrs_site_if.source site_o
);
  import rrs_pkg::*;

  cfg_t  cfg;
  cand_t cand;
  logic  cand_valid;
  logic  cand_ready;

  rrs_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rrs_decode #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .code_i       (code_i),
    .cand_o       (cand),
    .cand_valid_o (cand_valid),
    .cand_ready_i (cand_ready)
  );

  rrs_resolve u_resolve (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cand_i       (cand),
    .cand_valid_i (cand_valid),
    .cand_ready_o (cand_ready),
    .site_o       (site_o)
  );

endmodule

`default_nettype wire
